FILE: sv/bsup_pkg.sv
`default_nettype none
package bsup_pkg;

  // Field widths
  localparam int unsigned READING_W     = 12;
  localparam int unsigned TICKS_W       = 8;
  localparam int unsigned SHUT_W        = 10;
  localparam int unsigned USAGE_W       = 32;
  localparam int unsigned MINUTES_OUT_W = 16;
  localparam int unsigned WARN_W        = 2;

  // Usage report timing
  localparam int unsigned START_MINUTES    = 20;
  localparam int unsigned GAP_MINUTES      = 20;
  localparam int unsigned TICKS_PER_MINUTE = 600;

  // Usage time is kept as ticks within the minute, whole minutes and
  // minutes since the last report, so no divider is needed.
  localparam int unsigned SUB_W = (TICKS_PER_MINUTE > 1) ? $clog2(TICKS_PER_MINUTE) : 1;
  localparam int unsigned MIN_W = USAGE_W - $clog2(TICKS_PER_MINUTE) + 1;
  localparam int unsigned GAP_W = (GAP_MINUTES > 1) ? $clog2(GAP_MINUTES + 1) : 1;

  localparam logic [SUB_W-1:0] SUB_LAST   = SUB_W'(TICKS_PER_MINUTE - 1);
  localparam logic [MIN_W-1:0] START_MINS = MIN_W'(START_MINUTES);
  localparam logic [GAP_W-1:0] GAP_LAST   = GAP_W'(GAP_MINUTES - 1);

  // Configuration port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CRITICAL_MAX   = 3'd0,
    REG_LOW_BAND_MIN   = 3'd1,
    REG_LOW_BAND_MAX   = 3'd2,
    REG_NORMAL_MIN     = 3'd3,
    REG_CRITICAL_TICKS = 3'd4,
    REG_LOW_TICKS      = 3'd5,
    REG_NORMAL_TICKS   = 3'd6,
    REG_SHUTDOWN_TICKS = 3'd7
  } reg_e;

  localparam logic [READING_W-1:0] CRITICAL_MAX_RST   = 12'd1190;
  localparam logic [READING_W-1:0] LOW_BAND_MIN_RST   = 12'd1210;
  localparam logic [READING_W-1:0] LOW_BAND_MAX_RST   = 12'd1290;
  localparam logic [READING_W-1:0] NORMAL_MIN_RST     = 12'd1310;
  localparam logic [TICKS_W-1:0]   CRITICAL_TICKS_RST = 8'd50;
  localparam logic [TICKS_W-1:0]   LOW_TICKS_RST      = 8'd20;
  localparam logic [TICKS_W-1:0]   NORMAL_TICKS_RST   = 8'd10;
  localparam logic [SHUT_W-1:0]    SHUTDOWN_TICKS_RST = 10'd600;

  typedef enum logic [1:0] {
    ST_NORMAL   = 2'd0,
    ST_LOW      = 2'd1,
    ST_CRITICAL = 2'd2
  } status_e;

  typedef struct packed {
    logic [READING_W-1:0] critical_max;
    logic [READING_W-1:0] low_band_min;
    logic [READING_W-1:0] low_band_max;
    logic [READING_W-1:0] normal_min;
    logic [TICKS_W-1:0]   critical_ticks;
    logic [TICKS_W-1:0]   low_ticks;
    logic [TICKS_W-1:0]   normal_ticks;
    logic [SHUT_W-1:0]    shutdown_ticks;
  } cfg_t;

  typedef struct packed {
    logic                     low_power_mark;
    logic [1:0]               battery_status;
    logic                     shutdown_request;
    logic [MINUTES_OUT_W-1:0] report_minutes;
    logic                     report_valid;
    logic                     warn_off;
    logic [WARN_W-1:0]        warn_on_count;
  } res_t;

endpackage
`default_nettype wire

FILE: sv/bsup_cfg_regs.sv
`default_nettype none
module bsup_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bsup_pkg::ADDR_W-1:0]     paddr,
  input  wire logic [bsup_pkg::DATA_W-1:0]     pwdata,
  output logic      [bsup_pkg::DATA_W-1:0]     prdata,
  output logic                                 pready,
  output bsup_pkg::cfg_t                       cfg_o
);

  bsup_pkg::cfg_t  cfg_q;
  bsup_pkg::reg_e  reg_sel;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_sel = bsup_pkg::reg_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;
  assign cfg_o   = cfg_q;

  // Register file, written in the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.critical_max   <= bsup_pkg::CRITICAL_MAX_RST;
      cfg_q.low_band_min   <= bsup_pkg::LOW_BAND_MIN_RST;
      cfg_q.low_band_max   <= bsup_pkg::LOW_BAND_MAX_RST;
      cfg_q.normal_min     <= bsup_pkg::NORMAL_MIN_RST;
      cfg_q.critical_ticks <= bsup_pkg::CRITICAL_TICKS_RST;
      cfg_q.low_ticks      <= bsup_pkg::LOW_TICKS_RST;
      cfg_q.normal_ticks   <= bsup_pkg::NORMAL_TICKS_RST;
      cfg_q.shutdown_ticks <= bsup_pkg::SHUTDOWN_TICKS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        bsup_pkg::REG_CRITICAL_MAX:   cfg_q.critical_max   <= pwdata[11:0];
        bsup_pkg::REG_LOW_BAND_MIN:   cfg_q.low_band_min   <= pwdata[11:0];
        bsup_pkg::REG_LOW_BAND_MAX:   cfg_q.low_band_max   <= pwdata[11:0];
        bsup_pkg::REG_NORMAL_MIN:     cfg_q.normal_min     <= pwdata[11:0];
        bsup_pkg::REG_CRITICAL_TICKS: cfg_q.critical_ticks <= pwdata[7:0];
        bsup_pkg::REG_LOW_TICKS:      cfg_q.low_ticks      <= pwdata[7:0];
        bsup_pkg::REG_NORMAL_TICKS:   cfg_q.normal_ticks   <= pwdata[7:0];
        bsup_pkg::REG_SHUTDOWN_TICKS: cfg_q.shutdown_ticks <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      bsup_pkg::REG_CRITICAL_MAX:   prdata = 32'(cfg_q.critical_max);
      bsup_pkg::REG_LOW_BAND_MIN:   prdata = 32'(cfg_q.low_band_min);
      bsup_pkg::REG_LOW_BAND_MAX:   prdata = 32'(cfg_q.low_band_max);
      bsup_pkg::REG_NORMAL_MIN:     prdata = 32'(cfg_q.normal_min);
      bsup_pkg::REG_CRITICAL_TICKS: prdata = 32'(cfg_q.critical_ticks);
      bsup_pkg::REG_LOW_TICKS:      prdata = 32'(cfg_q.low_ticks);
      bsup_pkg::REG_NORMAL_TICKS:   prdata = 32'(cfg_q.normal_ticks);
      bsup_pkg::REG_SHUTDOWN_TICKS: prdata = 32'(cfg_q.shutdown_ticks);
      default:                      prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/bsup_core.sv
`default_nettype none
module bsup_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               step_i,
  input  wire logic [bsup_pkg::READING_W-1:0]     reading_i,
  input  wire logic                               ignition_i,
  input  wire bsup_pkg::cfg_t                     cfg_i,
  output bsup_pkg::res_t                          res_o
);

  logic [bsup_pkg::TICKS_W-1:0] crit_cnt_q, crit_cnt_d;
  logic [bsup_pkg::TICKS_W-1:0] low_cnt_q, low_cnt_d;
  logic [bsup_pkg::TICKS_W-1:0] norm_cnt_q, norm_cnt_d;
  bsup_pkg::status_e            status_q, status_d;
  logic                         low_power_q, low_power_d;
  logic                         prev_ign_q, prev_ign_d;
  logic                         warn_act_q, warn_act_d;
  logic [bsup_pkg::SHUT_W-1:0]  off_q, off_d, off_inc;
  logic [bsup_pkg::USAGE_W-1:0] usage_q, usage_d;
  logic [bsup_pkg::SUB_W-1:0]   sub_q, sub_d;
  logic [bsup_pkg::MIN_W-1:0]   min_q, min_d;
  logic [bsup_pkg::GAP_W-1:0]   gap_q, gap_d;

  logic                         in_crit, in_low, in_norm;
  logic [bsup_pkg::WARN_W-1:0]  warn_on;
  logic                         warn_off, rep_valid, shut;
  logic [bsup_pkg::MINUTES_OUT_W-1:0] rep_min;

  // Band decode: critical wins over low, low over normal.
  assign in_crit = reading_i <= cfg_i.critical_max;
  assign in_low  = !in_crit && reading_i >= cfg_i.low_band_min &&
                   reading_i <= cfg_i.low_band_max;
  assign in_norm = !in_crit && !in_low && reading_i >= cfg_i.normal_min;
  assign off_inc = off_q + 1'b1;

  // Next-state and result logic for one tick.
  always_comb begin
    crit_cnt_d  = crit_cnt_q;
    low_cnt_d   = low_cnt_q;
    norm_cnt_d  = norm_cnt_q;
    status_d    = status_q;
    low_power_d = low_power_q;
    prev_ign_d  = ignition_i;
    warn_act_d  = warn_act_q;
    off_d       = off_q;
    usage_d     = usage_q;
    sub_d       = sub_q;
    min_d       = min_q;
    gap_d       = gap_q;
    warn_on     = '0;
    warn_off    = 1'b0;
    rep_valid   = 1'b0;
    rep_min     = '0;
    shut        = 1'b0;

    // Band counters qualify the status.
    if (in_crit) begin
      if (crit_cnt_q < cfg_i.critical_ticks) crit_cnt_d = crit_cnt_q + 1'b1;
      else status_d = bsup_pkg::ST_CRITICAL;
      low_cnt_d  = '0;
      norm_cnt_d = '0;
    end else if (in_low) begin
      if (low_cnt_q < cfg_i.low_ticks) low_cnt_d = low_cnt_q + 1'b1;
      else status_d = bsup_pkg::ST_LOW;
      crit_cnt_d = '0;
      norm_cnt_d = '0;
    end else if (in_norm) begin
      if (norm_cnt_q < cfg_i.normal_ticks) norm_cnt_d = norm_cnt_q + 1'b1;
      else status_d = bsup_pkg::ST_NORMAL;
      crit_cnt_d = '0;
      low_cnt_d  = '0;
    end
    if (status_d == bsup_pkg::ST_NORMAL) low_power_d = 1'b0;

    // Ignition rising while critical raises a warning.
    if (prev_ign_q != ignition_i && ignition_i && status_d == bsup_pkg::ST_CRITICAL) begin
      warn_on    = warn_on + 1'b1;
      warn_act_d = 1'b1;
    end

    if (!ignition_i || status_d == bsup_pkg::ST_CRITICAL) begin
      // Shutdown timer runs; usage time is dropped.
      usage_d = '0;
      sub_d   = '0;
      min_d   = '0;
      gap_d   = '0;
      off_d   = off_inc;
      if (off_inc == bsup_pkg::SHUT_W'(1) && ignition_i) begin
        warn_act_d = 1'b1;
        warn_on    = warn_on + 1'b1;
      end
      if (off_inc == cfg_i.shutdown_ticks) begin
        off_d       = '0;
        low_power_d = 1'b1;
        shut        = 1'b1;
        warn_act_d  = 1'b0;
      end
    end else begin
      if (warn_act_q) begin
        warn_off   = 1'b1;
        warn_act_d = 1'b0;
      end
      off_d = '0;
      if (status_d == bsup_pkg::ST_LOW) begin
        // Usage time advances one tick; counters wrap with the 32-bit count.
        if (usage_q == '1) begin
          usage_d = '0;
          sub_d   = '0;
          min_d   = '0;
          gap_d   = '0;
        end else begin
          usage_d = usage_q + 1'b1;
          if (sub_q == bsup_pkg::SUB_LAST) begin
            sub_d = '0;
            min_d = min_q + 1'b1;
            if (min_d == bsup_pkg::START_MINS) gap_d = '0;
            else if (min_d > bsup_pkg::START_MINS)
              gap_d = (gap_q == bsup_pkg::GAP_LAST) ? '0 : gap_q + 1'b1;
          end else begin
            sub_d = sub_q + 1'b1;
          end
        end
        if (sub_d == '0 && min_d >= bsup_pkg::START_MINS && gap_d == '0) begin
          rep_valid = 1'b1;
          rep_min   = bsup_pkg::MINUTES_OUT_W'(min_d);
        end
      end else begin
        if (usage_q != '0) rep_valid = 1'b1;
        usage_d = '0;
        sub_d   = '0;
        min_d   = '0;
        gap_d   = '0;
      end
    end
  end

  // Supervisor state, advanced once per tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_cnt_q  <= '0;
      low_cnt_q   <= '0;
      norm_cnt_q  <= '0;
      status_q    <= bsup_pkg::ST_NORMAL;
      low_power_q <= 1'b0;
      prev_ign_q  <= 1'b1;
      warn_act_q  <= 1'b0;
      off_q       <= '0;
      usage_q     <= '0;
      sub_q       <= '0;
      min_q       <= '0;
      gap_q       <= '0;
    end else if (step_i) begin
      crit_cnt_q  <= crit_cnt_d;
      low_cnt_q   <= low_cnt_d;
      norm_cnt_q  <= norm_cnt_d;
      status_q    <= status_d;
      low_power_q <= low_power_d;
      prev_ign_q  <= prev_ign_d;
      warn_act_q  <= warn_act_d;
      off_q       <= off_d;
      usage_q     <= usage_d;
      sub_q       <= sub_d;
      min_q       <= min_d;
      gap_q       <= gap_d;
    end
  end

  assign res_o.warn_on_count    = warn_on;
  assign res_o.warn_off         = warn_off;
  assign res_o.report_valid     = rep_valid;
  assign res_o.report_minutes   = rep_min;
  assign res_o.shutdown_request = shut;
  assign res_o.battery_status   = status_d;
  assign res_o.low_power_mark   = low_power_d;

endmodule
`default_nettype wire

FILE: sv/battery_usage_supervisor.sv
// Battery usage supervisor.
// One input word per 100 ms tick arrives on the s_axis channel: the battery
// converter sample and the ignition level. Every word yields exactly one
// result word on the m_axis channel: warning on/off counts, a usage report
// (minutes while the status is low, zero when low status ends), a shutdown
// request pulse, the qualified battery status and the low-power mark.
// The word passes an input register, one pass of compare and counter logic
// and a result register, which raises m_axis_tvalid; a new word is taken in
// every cycle while the receiver takes the results.
// When the receiver stalls, the result register holds its word and the input
// register keeps taking one more word; after that s_axis_tready drops until
// the result is taken. No word is lost or repeated.
// Thresholds and tick limits sit in eight APB registers at byte addresses
// 0x00..0x1C; the user writes them only while the stream is idle, which the
// block does not enforce. Reset brings the registers to their defaults, the
// status to normal, all counters to zero and the remembered ignition level to on.
`default_nettype none
module battery_usage_supervisor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input word: [11:0] battery_reading, [12] ignition_on, [15:13] zero
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,
  // Result word: [1:0] warn_on_count, [2] warn_off, [3] report_valid,
  // [19:4] report_minutes, [20] shutdown_request, [22:21] battery_status,
  // [23] low_power_mark
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [23:0]                        m_axis_tdata,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [bsup_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bsup_pkg::DATA_W-1:0]   pwdata,
  output logic      [bsup_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);

  bsup_pkg::cfg_t                   cfg;
  bsup_pkg::res_t                   res, out_q;
  logic                             in_valid_q, out_valid_q, advance;
  logic [bsup_pkg::READING_W-1:0]   reading_q;
  logic                             ign_q;

  bsup_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the input word moves on when the result register is free.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      reading_q <= s_axis_tdata[11:0];
      ign_q     <= s_axis_tdata[12];
    end
  end

  bsup_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .reading_i  (reading_q),
    .ignition_i (ign_q),
    .cfg_i      (cfg),
    .res_o      (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
`default_nettype wire

FILE: tb/sv/bsup_checker.sv
module bsup_checker
  import bsup_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  // Input word: [11:0] battery_reading, [12] ignition_on, [15:13] zero
  input  wire logic [15:0]         s_axis_tdata,
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // Result word: [1:0] warn_on_count, [2] warn_off, [3] report_valid,
  // [19:4] report_minutes, [20] shutdown_request, [22:21] battery_status,
  // [23] low_power_mark
  input  wire logic [23:0]         m_axis_tdata,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [DATA_W-1:0]   pwdata,
  input  wire logic [DATA_W-1:0]   prdata,
  input  wire logic                pready,
  output int                       errors_o,
  output int                       pending_o
);

  localparam logic [USAGE_W-1:0] START_TICKS = USAGE_W'(START_MINUTES * TICKS_PER_MINUTE);
  localparam logic [USAGE_W-1:0] GAP_TICKS   = USAGE_W'(GAP_MINUTES * TICKS_PER_MINUTE);

  // Shadow copy of the thresholds and the supervisor state.
  cfg_t                  cfg;
  logic [TICKS_W-1:0]    crit_cnt;
  logic [TICKS_W-1:0]    low_cnt;
  logic [TICKS_W-1:0]    norm_cnt;
  status_e               status;
  logic                  lp_mark;
  logic                  prev_ign;
  logic                  warn_active;
  logic [SHUT_W-1:0]     off_cnt;
  logic [USAGE_W-1:0]    usage;

  res_t                  expected_results [$];
  int unsigned           result_no = 0;
  int                    mismatches = 0;
  int                    waiting = 0;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on result %0d: %s is %0d, expected %0d", result_no, what, got, want);
    mismatches++;
  endtask

  // Advance the supervisor by one tick and work out the result word it gives.
  task automatic supervise_tick(input logic [READING_W-1:0] rd, input logic ign,
                                output res_t r);
    r = '0;
    // Band check: critical wins over low, low wins over normal; dead zones do nothing.
    if (rd <= cfg.critical_max) begin
      if (crit_cnt < cfg.critical_ticks) crit_cnt = crit_cnt + 1'b1;
      else status = ST_CRITICAL;
      low_cnt  = '0;
      norm_cnt = '0;
    end else if (rd >= cfg.low_band_min && rd <= cfg.low_band_max) begin
      if (low_cnt < cfg.low_ticks) low_cnt = low_cnt + 1'b1;
      else status = ST_LOW;
      crit_cnt = '0;
      norm_cnt = '0;
    end else if (rd >= cfg.normal_min) begin
      if (norm_cnt < cfg.normal_ticks) norm_cnt = norm_cnt + 1'b1;
      else status = ST_NORMAL;
      crit_cnt = '0;
      low_cnt  = '0;
    end
    if (status == ST_NORMAL) lp_mark = 1'b0;

    // Ignition edge: rising while critical raises a warning.
    if (prev_ign != ign) begin
      prev_ign = ign;
      if (status == ST_CRITICAL && ign) begin
        r.warn_on_count = r.warn_on_count + 1'b1;
        warn_active = 1'b1;
      end
    end

    // Shutdown timer runs while ignition is off or the battery is critical.
    if (!ign || status == ST_CRITICAL) begin
      usage   = '0;
      off_cnt = off_cnt + 1'b1;
      if (off_cnt == SHUT_W'(1) && ign) begin
        warn_active = 1'b1;
        r.warn_on_count = r.warn_on_count + 1'b1;
      end
      if (off_cnt == cfg.shutdown_ticks) begin
        off_cnt = '0;
        lp_mark = 1'b1;
        r.shutdown_request = 1'b1;
        warn_active = 1'b0;
      end
    end else begin
      if (warn_active) begin
        r.warn_off = 1'b1;
        warn_active = 1'b0;
      end
      off_cnt = '0;
      // Usage reports while low: first after the start delay, then at each gap.
      if (status == ST_LOW) begin
        usage = usage + 1'b1;
        if (usage >= START_TICKS && ((usage - START_TICKS) % GAP_TICKS) == 0) begin
          r.report_valid   = 1'b1;
          r.report_minutes = MINUTES_OUT_W'(usage / TICKS_PER_MINUTE);
        end
      end else begin
        if (usage != '0) begin
          r.report_valid   = 1'b1;
          r.report_minutes = '0;
        end
        usage = '0;
      end
    end
    r.battery_status = status;
    r.low_power_mark = lp_mark;
  endtask

  // Watch the register port and both streams on every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t got;
    res_t want;
    logic [DATA_W-1:0] reg_value;
    if (!rst_ni) begin
      cfg.critical_max   = CRITICAL_MAX_RST;
      cfg.low_band_min   = LOW_BAND_MIN_RST;
      cfg.low_band_max   = LOW_BAND_MAX_RST;
      cfg.normal_min     = NORMAL_MIN_RST;
      cfg.critical_ticks = CRITICAL_TICKS_RST;
      cfg.low_ticks      = LOW_TICKS_RST;
      cfg.normal_ticks   = NORMAL_TICKS_RST;
      cfg.shutdown_ticks = SHUTDOWN_TICKS_RST;
      crit_cnt    = '0;
      low_cnt     = '0;
      norm_cnt    = '0;
      status      = ST_NORMAL;
      lp_mark     = 1'b0;
      prev_ign    = 1'b1;
      warn_active = 1'b0;
      off_cnt     = '0;
      usage       = '0;
      expected_results.delete();
      waiting <= 0;
    end else begin
      // Register access: writes update the shadow copy, reads are checked against it.
      if (psel && penable && pready) begin
        reg_value = '0;
        case (reg_e'(paddr[ADDR_W-1:2]))
          REG_CRITICAL_MAX: begin
            if (pwrite) cfg.critical_max = pwdata[READING_W-1:0];
            reg_value = DATA_W'(cfg.critical_max);
          end
          REG_LOW_BAND_MIN: begin
            if (pwrite) cfg.low_band_min = pwdata[READING_W-1:0];
            reg_value = DATA_W'(cfg.low_band_min);
          end
          REG_LOW_BAND_MAX: begin
            if (pwrite) cfg.low_band_max = pwdata[READING_W-1:0];
            reg_value = DATA_W'(cfg.low_band_max);
          end
          REG_NORMAL_MIN: begin
            if (pwrite) cfg.normal_min = pwdata[READING_W-1:0];
            reg_value = DATA_W'(cfg.normal_min);
          end
          REG_CRITICAL_TICKS: begin
            if (pwrite) cfg.critical_ticks = pwdata[TICKS_W-1:0];
            reg_value = DATA_W'(cfg.critical_ticks);
          end
          REG_LOW_TICKS: begin
            if (pwrite) cfg.low_ticks = pwdata[TICKS_W-1:0];
            reg_value = DATA_W'(cfg.low_ticks);
          end
          REG_NORMAL_TICKS: begin
            if (pwrite) cfg.normal_ticks = pwdata[TICKS_W-1:0];
            reg_value = DATA_W'(cfg.normal_ticks);
          end
          default: begin
            if (pwrite) cfg.shutdown_ticks = pwdata[SHUT_W-1:0];
            reg_value = DATA_W'(cfg.shutdown_ticks);
          end
        endcase
        if (!pwrite && prdata !== reg_value) report_mismatch("register read", prdata, reg_value);
      end

      // Result word: compare with the oldest expectation.
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata);
        if (expected_results.size() == 0) begin
          report_mismatch("word with nothing expected", got, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.warn_on_count !== want.warn_on_count)
            report_mismatch("warn_on_count", got.warn_on_count, want.warn_on_count);
          if (got.warn_off !== want.warn_off)
            report_mismatch("warn_off", got.warn_off, want.warn_off);
          if (got.report_valid !== want.report_valid)
            report_mismatch("report_valid", got.report_valid, want.report_valid);
          if (got.report_minutes !== want.report_minutes)
            report_mismatch("report_minutes", got.report_minutes, want.report_minutes);
          if (got.shutdown_request !== want.shutdown_request)
            report_mismatch("shutdown_request", got.shutdown_request, want.shutdown_request);
          if (got.battery_status !== want.battery_status)
            report_mismatch("battery_status", got.battery_status, want.battery_status);
          if (got.low_power_mark !== want.low_power_mark)
            report_mismatch("low_power_mark", got.low_power_mark, want.low_power_mark);
        end
        result_no++;
      end

      // Input word: predict the result it will give.
      if (s_axis_tvalid && s_axis_tready) begin
        supervise_tick(s_axis_tdata[READING_W-1:0], s_axis_tdata[READING_W], want);
        expected_results.push_back(want);
      end
      waiting <= expected_results.size();
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import bsup_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // Input word: [11:0] battery_reading, [12] ignition_on, [15:13] zero
  logic [15:0]         s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // Result word: [1:0] warn_on_count, [2] warn_off, [3] report_valid,
  // [19:4] report_minutes, [20] shutdown_request, [22:21] battery_status,
  // [23] low_power_mark
  logic [23:0]         m_axis_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int                  mismatches;
  int                  results_waiting;
  cfg_t                cfg_now;
  int unsigned         ticks_sent = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         hold_count = 0;
  bit                  steady_send = 1'b0;
  bit                  hold_armed = 1'b0;
  bit                  hold_done = 1'b0;

  battery_usage_supervisor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  bsup_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .errors_o      (mismatches),
    .pending_o     (results_waiting)
  );

  // Free-running clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off when armed.
  always @(posedge clk_i) begin
    if (hold_armed && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_count++;
      if (hold_count == HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: too many cycles without any word moving ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic cfg_t default_cfg();
    cfg_t c;
    c.critical_max   = CRITICAL_MAX_RST;
    c.low_band_min   = LOW_BAND_MIN_RST;
    c.low_band_max   = LOW_BAND_MAX_RST;
    c.normal_min     = NORMAL_MIN_RST;
    c.critical_ticks = CRITICAL_TICKS_RST;
    c.low_ticks      = LOW_TICKS_RST;
    c.normal_ticks   = NORMAL_TICKS_RST;
    c.shutdown_ticks = SHUTDOWN_TICKS_RST;
    return c;
  endfunction

  // Short tick limits; bands are either ordered with gaps or thrown at random.
  function automatic cfg_t random_cfg();
    cfg_t c;
    c.critical_ticks = TICKS_W'($urandom_range(12));
    c.low_ticks      = TICKS_W'($urandom_range(12));
    c.normal_ticks   = TICKS_W'($urandom_range(12));
    c.shutdown_ticks = SHUT_W'($urandom_range(40, 1));
    if ($urandom_range(3) == 0) begin
      // Overlapping or inverted bands, so the test priority matters.
      c.critical_max = READING_W'($urandom_range(4095));
      c.low_band_min = READING_W'($urandom_range(4095));
      c.low_band_max = READING_W'($urandom_range(4095));
      c.normal_min   = READING_W'($urandom_range(4095));
    end else begin
      c.critical_max = READING_W'($urandom_range(3200));
      c.low_band_min = c.critical_max + READING_W'($urandom_range(100, 1));
      c.low_band_max = c.low_band_min + READING_W'($urandom_range(300));
      c.normal_min   = c.low_band_max + READING_W'($urandom_range(100, 1));
    end
    return c;
  endfunction

  // A reading inside the band of the given status under the current thresholds, any reading if the low band is empty.
  function automatic logic [READING_W-1:0] pick_reading(input status_e band);
    case (band)
      ST_CRITICAL: return READING_W'($urandom_range(cfg_now.critical_max, 0));
      ST_LOW: begin
        if (cfg_now.low_band_min <= cfg_now.low_band_max)
          return READING_W'($urandom_range(cfg_now.low_band_max, cfg_now.low_band_min));
        return READING_W'($urandom_range(4095));
      end
      default: return READING_W'($urandom_range(4095, cfg_now.normal_min));
    endcase
  endfunction

  function automatic int unsigned band_limit(input status_e band);
    case (band)
      ST_CRITICAL: return cfg_now.critical_ticks;
      ST_LOW:      return cfg_now.low_ticks;
      default:     return cfg_now.normal_ticks;
    endcase
  endfunction

  // One register access: setup cycle, then access cycle until pready.
  task automatic apb_access(input logic wr, input reg_e idx, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  // Write every register, then read them all back.
  task automatic write_config(input cfg_t c);
    cfg_now = c;
    apb_access(1'b1, REG_CRITICAL_MAX,   DATA_W'(c.critical_max));
    apb_access(1'b1, REG_LOW_BAND_MIN,   DATA_W'(c.low_band_min));
    apb_access(1'b1, REG_LOW_BAND_MAX,   DATA_W'(c.low_band_max));
    apb_access(1'b1, REG_NORMAL_MIN,     DATA_W'(c.normal_min));
    apb_access(1'b1, REG_CRITICAL_TICKS, DATA_W'(c.critical_ticks));
    apb_access(1'b1, REG_LOW_TICKS,      DATA_W'(c.low_ticks));
    apb_access(1'b1, REG_NORMAL_TICKS,   DATA_W'(c.normal_ticks));
    apb_access(1'b1, REG_SHUTDOWN_TICKS, DATA_W'(c.shutdown_ticks));
    for (int i = 0; i < 8; i++) apb_access(1'b0, reg_e'(i[2:0]), '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one word and wait until it is taken; idling follows a rotating mode.
  task automatic send_tick(input logic [READING_W-1:0] rd, input logic ign);
    int unsigned mode;
    int unsigned idle_pct;
    mode = (ticks_sent / 97) % 4;
    idle_pct = steady_send ? 0 : (mode == 1) ? 50 : (mode == 3) ? 35 : 0;
    recv_stall_pct = (mode == 2) ? 50 : (mode == 3) ? 35 : 0;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, ign, rd};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_waiting != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly runs that hold one band long enough to change status, some noise.
  task automatic random_ticks(input int unsigned count);
    int unsigned left;
    int unsigned len;
    int unsigned ign_mode;
    status_e band;
    logic ign;
    logic [READING_W-1:0] rd;
    left = count;
    while (left > 0) begin
      if ($urandom_range(99) < 15) begin
        send_tick(READING_W'($urandom_range(4095)), 1'($urandom_range(1)));
        left--;
      end else begin
        band = status_e'($urandom_range(2));
        ign_mode = $urandom_range(9);
        if (ign_mode == 7 || ign_mode == 8)
          len = $urandom_range(cfg_now.shutdown_ticks + 5, 1);
        else
          len = $urandom_range(band_limit(band) + 4, 1);
        for (int i = 0; i < len && left > 0; i++) begin
          ign = (ign_mode < 7) ? 1'b1 : (ign_mode < 9) ? 1'b0 : 1'($urandom_range(1));
          rd = ($urandom_range(9) == 0) ? READING_W'($urandom_range(4095)) : pick_reading(band);
          send_tick(rd, ign);
          left--;
        end
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    cfg_t c;
    cfg_now = default_cfg();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults after reset: ignition drop, full-scale reading, dead zone.
    send_tick(12'd0, 1'b0);
    send_tick(12'd4095, 1'b1);
    send_tick(12'd1300, 1'b1);
    settle();

    // Directed walk with one-tick critical and low limits, a zero normal limit and a three-tick shutdown timer.
    c = default_cfg();
    c.critical_ticks = 8'd1;
    c.low_ticks      = 8'd1;
    c.normal_ticks   = 8'd0;
    c.shutdown_ticks = 10'd3;
    write_config(c);
    // Enter low, pass a dead zone, then a normal word ends low and reports zero.
    send_tick(12'd1250, 1'b1);
    send_tick(12'd1250, 1'b1);
    send_tick(12'd1200, 1'b1);
    send_tick(12'd1320, 1'b1);
    // Go critical, drop ignition until shutdown, then raise it while critical,
    // which gives two warnings in the same word.
    send_tick(12'd0, 1'b1);
    send_tick(12'd0, 1'b1);
    send_tick(12'd1190, 1'b0);
    send_tick(12'd1190, 1'b0);
    send_tick(12'd1190, 1'b1);
    send_tick(12'd1190, 1'b1);
    send_tick(12'd1190, 1'b1);
    // Back to normal, critical again, and normal once more to switch the warning off.
    send_tick(12'd4095, 1'b1);
    send_tick(12'd0, 1'b1);
    send_tick(12'd0, 1'b1);
    send_tick(12'd4095, 1'b1);
    // Band edges and both dead-zone edges.
    send_tick(12'd1210, 1'b1);
    send_tick(12'd1290, 1'b1);
    send_tick(12'd1291, 1'b1);
    send_tick(12'd1309, 1'b1);
    // Shutdown while normal: the mark is cleared and set again in one word.
    send_tick(12'd1310, 1'b0);
    send_tick(12'd1311, 1'b0);
    send_tick(12'd1310, 1'b0);
    send_tick(12'd2048, 1'b1);
    send_tick(12'd4094, 1'b0);
    send_tick(12'd1, 1'b1);
    settle();

    // Random phases: the two extreme settings first, then random ones.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          c.critical_max   = '0;
          c.low_band_min   = '0;
          c.low_band_max   = '0;
          c.normal_min     = '0;
          c.critical_ticks = '0;
          c.low_ticks      = '0;
          c.normal_ticks   = '0;
          c.shutdown_ticks = 10'd1;
        end
        1: begin
          c.critical_max   = '1;
          c.low_band_min   = '1;
          c.low_band_max   = '1;
          c.normal_min     = '1;
          c.critical_ticks = '1;
          c.low_ticks      = '1;
          c.normal_ticks   = '1;
          c.shutdown_ticks = '1;
        end
        default: c = random_cfg();
      endcase
      write_config(c);
      random_ticks(65);
      settle();
    end

    // Long receiver hold-off while the sender keeps offering words.
    write_config(random_cfg());
    hold_armed  = 1'b1;
    steady_send = 1'b1;
    random_ticks(60);
    steady_send = 1'b0;
    settle();

    // A last stretch of random words under a random setting.
    write_config(random_cfg());
    random_ticks(40);
    settle();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && results_waiting == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
